// ===== rtl/core/ktk_pkg.sv =====
// Types and codes shared by the keyed top-k table modules.
package ktk_pkg;

    localparam int SCORE_BITS = 63;
    localparam int KEY_IN_BITS = 32;
    localparam int RANK_BITS = 6;
    localparam int POS_BITS = 7;
    localparam int STATUS_BITS = 3;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_NOT_ENTERED = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_ENTERED     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_BEAT        = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_BEATEN  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_IGNORED     = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_READ        = 3'd5;

    typedef struct packed {
        logic                   command;
        logic [KEY_IN_BITS-1:0] key;
        logic [SCORE_BITS-1:0]  score;
        logic [RANK_BITS-1:0]   rank;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [POS_BITS-1:0]    position;
        logic                   old_found;
        logic [POS_BITS-1:0]    old_position;
        logic [SCORE_BITS-1:0]  prior_score;
        logic                   read_valid;
        logic [KEY_IN_BITS-1:0] read_key;
        logic [SCORE_BITS-1:0]  read_score;
    } out_item_t;

endpackage

// ===== rtl/core/ktk_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ktk_ram #(
    parameter int WIDTH = 95,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/ktk_ctrl.sv =====
// Sequencer: key scan, upward bubble and read over the entry RAM.
module ktk_ctrl import ktk_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS = 32,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int EW = KEY_BITS + SCORE_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_item_t      s_item,
    output logic          res_valid,
    input  logic          res_ready,
    output out_item_t     res_item,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [EW-1:0] ram_wdata,
    output logic [AW-1:0] ram_raddr,
    input  logic [EW-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_SCAN,
        S_BUBBLE,
        S_WRITE,
        S_DONE
    } state_t;

    state_t            state_reg;
    in_item_t          item_reg;
    out_item_t         res_reg;
    logic [CW-1:0]     cnt_reg;
    logic [AW-1:0]     pos_reg;
    logic [EW-1:0]     mov_reg;

    logic [KEY_BITS-1:0]   rd_key;
    logic [SCORE_BITS-1:0] rd_score;
    logic [63:0]           rd_key64;
    logic [63:0]           in_key64;
    logic [63:0]           it_key64;
    logic [KEY_BITS-1:0]   in_key;
    logic [KEY_BITS-1:0]   it_key;
    logic [63:0]           rank64;
    logic [AW-1:0]         rank_addr;
    logic [31:0]           pos_p1;
    logic [POS_BITS-1:0]   pos1;
    logic                  hit;
    logic                  last_used;
    logic                  full;
    logic                  ge;

    assign rd_key    = ram_rdata[EW-1:SCORE_BITS];
    assign rd_score  = ram_rdata[SCORE_BITS-1:0];
    assign rd_key64  = 64'(rd_key);
    assign in_key64  = 64'(s_item.key);
    assign it_key64  = 64'(item_reg.key);
    assign in_key    = in_key64[KEY_BITS-1:0];
    assign it_key    = it_key64[KEY_BITS-1:0];
    assign rank64    = 64'(s_item.rank);
    assign rank_addr = rank64[AW-1:0];
    assign pos_p1    = 32'(pos_reg) + 32'd1;
    assign pos1      = pos_p1[POS_BITS-1:0];
    assign hit       = (rd_key == it_key);
    assign last_used = ((CW'(pos_reg) + CW'(1)) == cnt_reg);
    assign full      = (cnt_reg == CW'(TABLE_DEPTH));
    assign ge        = (item_reg.score >= rd_score);

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_item  = res_reg;

    always_comb begin
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = mov_reg;
        case (state_reg)
            S_IDLE: begin
                ram_raddr = (s_item.command == CMD_READ) ? rank_addr : '0;
            end
            S_SCAN: begin
                if (hit) begin
                    ram_raddr = pos_reg - AW'(1);
                end else if (last_used) begin
                    ram_raddr = full ? AW'(TABLE_DEPTH - 2) : pos_reg;
                end else begin
                    ram_raddr = pos_reg + AW'(1);
                end
            end
            S_BUBBLE: begin
                if (ge) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    ram_raddr = pos_reg - AW'(2);
                end
            end
            S_WRITE: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_item;
                        res_reg  <= '0;
                        pos_reg  <= '0;
                        if (s_item.command == CMD_READ) begin
                            res_reg.status <= ST_READ;
                            if (32'(s_item.rank) < 32'(cnt_reg)) begin
                                state_reg <= S_RDWAIT;
                            end else begin
                                state_reg <= S_DONE;
                            end
                        end else if (s_item.score == '0) begin
                            res_reg.status <= ST_IGNORED;
                            state_reg      <= S_DONE;
                        end else if (cnt_reg == '0) begin
                            mov_reg        <= {in_key, s_item.score};
                            cnt_reg        <= CW'(1);
                            res_reg.status <= ST_ENTERED;
                            state_reg      <= S_WRITE;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_RDWAIT: begin
                    res_reg.read_valid <= 1'b1;
                    res_reg.read_key   <= rd_key64[KEY_IN_BITS-1:0];
                    res_reg.read_score <= rd_score;
                    state_reg          <= S_DONE;
                end
                S_SCAN: begin
                    if (hit) begin
                        res_reg.old_found    <= 1'b1;
                        res_reg.old_position <= pos1;
                        res_reg.prior_score  <= rd_score;
                        res_reg.status <= (item_reg.score > rd_score) ? ST_BEAT : ST_NOT_BEATEN;
                        mov_reg <= {it_key, ge ? item_reg.score : rd_score};
                        state_reg <= (pos_reg == '0) ? S_WRITE : S_BUBBLE;
                    end else if (last_used) begin
                        if (!full) begin
                            mov_reg        <= {it_key, item_reg.score};
                            cnt_reg        <= cnt_reg + CW'(1);
                            pos_reg        <= pos_reg + AW'(1);
                            res_reg.status <= ST_ENTERED;
                            state_reg      <= S_BUBBLE;
                        end else if (!ge) begin
                            res_reg.status <= ST_NOT_ENTERED;
                            state_reg      <= S_DONE;
                        end else begin
                            mov_reg        <= {it_key, item_reg.score};
                            pos_reg        <= AW'(TABLE_DEPTH - 1);
                            res_reg.status <= ST_ENTERED;
                            state_reg      <= S_BUBBLE;
                        end
                    end else begin
                        pos_reg <= pos_reg + AW'(1);
                    end
                end
                S_BUBBLE: begin
                    if (ge) begin
                        pos_reg <= pos_reg - AW'(1);
                        if (pos_reg == AW'(1)) begin
                            state_reg <= S_WRITE;
                        end
                    end else begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    res_reg.position <= pos1;
                    state_reg        <= S_DONE;
                end
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/keyed_top_k_table_core.sv =====
// Keyed top-k table: top level with result register and checks.
//
// Holds up to TABLE_DEPTH (key, score) entries in one RAM, highest score
// first. One transaction is worked on at a time. A read waits for the
// RAM read data before its result; a zero score or an out-of-range read
// goes straight to the result. A submit scans ranks from the top until
// it meets its key or the last entry (one rank per cycle), then moves
// the entry upward one rank per cycle, then writes it. The entry RAM
// has a single read port. The table needs no clearing after reset; a
// fill count marks the occupied ranks. The result register lets the
// next transaction enter while a result waits.
module keyed_top_k_table_core import ktk_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = KEY_BITS + SCORE_BITS;

    logic          res_valid;
    logic          res_ready;
    out_item_t     res_item;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    logic          m_valid_reg;
    out_item_t     m_item_reg;

    ktk_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KEY_BITS(KEY_BITS)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_item(res_item),
        .ram_we(ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata)
    );

    ktk_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk(aclk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
                m_item_reg  <= res_item;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    a_read_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.read_valid |-> m_item_reg.status == ST_READ)
        else $error("read data on a non-read result");

    a_position_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_item_reg.status == ST_ENTERED || m_item_reg.status == ST_BEAT ||
        m_item_reg.status == ST_NOT_BEATEN) |-> m_item_reg.position != '0)
        else $error("entered result without position");

    a_ignored_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.status == ST_IGNORED |->
        !m_item_reg.old_found && m_item_reg.position == '0)
        else $error("zero-score result carries data");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("transaction accepted while busy");

endmodule
